// File: hdl/wmv_pkg.sv
// Shared constants for the windowed mean and variance block.
`default_nettype none

package wmv_pkg;

  // Default sizing of the sample series
  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Field widths of the stream payloads
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MEAN_W     = 24;
  localparam int unsigned VAR_W      = 40;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned OUT_DATA_W = MEAN_W + VAR_W;
  localparam int unsigned OUT_USER_W = 1;

  // Configuration register widths and reset values
  localparam int unsigned SPP_W       = 13;
  localparam int unsigned CENTRE_W    = 12;
  localparam int unsigned HALF_W      = 12;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam logic [SPP_W-1:0] SPP_RESET = 13'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLES_PER_PIXEL  = 2'd0,
    REG_EXCLUDE_ENABLE     = 2'd1,
    REG_CENTRE_INDEX       = 2'd2,
    REG_EXCLUDE_HALF_WIDTH = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: hdl/windowed_mean_variance.sv
// Per-pixel sample mean and unbiased variance over a windowed sample series.
//
// Usage:
//   Samples enter on the s_ stream, one per transaction, grouped into pixels
//   of samples_per_pixel samples (0 acts as 1, values above MAX_SAMPLES are
//   clamped). With exclude_enable set, samples whose position lies within
//   exclude_half_width of centre_index are skipped. After the last sample of a
//   pixel one transaction leaves on the m_ stream: mean and unbiased variance,
//   both with 8 fractional bits and truncated; tuser flags fewer than two
//   included samples (variance then zero).
// Timing:
//   An included sample runs through the sum and square accumulation states,
//   an excluded one is taken in the idle state alone; s_tready is low while
//   accumulating. Closing a pixel runs one shared adder through three
//   shift-add multiplies and two restoring divisions, one bit per cycle;
//   with fewer than two included samples only the mean division runs (one
//   sample) or none (no samples).
// Reset clears the accumulators, the position and the registers to defaults.
// The result sits in an output register; the next pixel accumulates while it
// waits, and only the close of that next pixel holds until it is taken.
`default_nettype none

module windowed_mean_variance #(
  parameter int unsigned MAX_SAMPLES = wmv_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = wmv_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [wmv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [wmv_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Sample stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [wmv_pkg::SAMPLE_W-1:0]        s_tdata,  // [15:0] sample
  // Result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [wmv_pkg::OUT_DATA_W-1:0]           m_tdata,  // [23:0] mean_value,
                                                             // [63:24] variance_value
  output logic [wmv_pkg::OUT_USER_W-1:0]           m_tuser   // [0] too_few_samples
);

  // Derived widths
  localparam int unsigned LOG_MAX = $clog2(MAX_SAMPLES);
  localparam int unsigned POS_W   = LOG_MAX;
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + LOG_MAX;
  localparam int unsigned SQ_W    = 2 * SAMPLE_BITS + LOG_MAX;
  localparam int unsigned NUM_W   = CNT_W + SQ_W;
  localparam int unsigned DEN_W   = 2 * CNT_W;
  localparam int unsigned ADD_W   = NUM_W;
  localparam int unsigned DVD_W   = NUM_W + wmv_pkg::FRAC_BITS;
  localparam int unsigned CTR_W   = $clog2(DVD_W);
  localparam int unsigned LEN_W   = (CNT_W > wmv_pkg::SPP_W) ? CNT_W : wmv_pkg::SPP_W;
  localparam int unsigned WIN_W   =
    ((POS_W > wmv_pkg::CENTRE_W) ? POS_W : wmv_pkg::CENTRE_W) + 1;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_ACC_SUM = 11'b000_0000_0010,
    ST_ACC_SQ  = 11'b000_0000_0100,
    ST_FIN     = 11'b000_0000_1000,
    ST_MUL_A   = 11'b000_0001_0000,
    ST_MUL_B   = 11'b000_0010_0000,
    ST_SUB     = 11'b000_0100_0000,
    ST_MUL_C   = 11'b000_1000_0000,
    ST_DIVV    = 11'b001_0000_0000,
    ST_DIVM    = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  // Configuration registers
  logic [wmv_pkg::SPP_W-1:0]    spp;
  logic                         exclude_enable;
  logic [wmv_pkg::CENTRE_W-1:0] centre_index;
  logic [wmv_pkg::HALF_W-1:0]   half_width;

  // Sequencer and accumulator state
  state_t                 state;
  logic [POS_W-1:0]       pos;
  logic [SUM_W-1:0]       sum;
  logic [SQ_W-1:0]        sumsq;
  logic [CNT_W-1:0]       count;
  logic [SAMPLE_BITS-1:0] s_reg;
  logic [2*SAMPLE_BITS-1:0] sq_reg;
  logic                   last_reg;

  // Working registers of the shared unit
  logic [ADD_W-1:0]       acc;
  logic [ADD_W-1:0]       mcand;
  logic [SUM_W-1:0]       mplier;
  logic [ADD_W-1:0]       t1;
  logic [DEN_W-1:0]       den;
  logic [DEN_W-1:0]       rem;
  logic [DVD_W-1:0]       dvd;
  logic [CTR_W-1:0]       cnt;
  logic [wmv_pkg::MEAN_W-1:0] mean_r;
  logic [wmv_pkg::VAR_W-1:0]  var_r;

  // Shared adder
  logic [ADD_W-1:0]       alu_a;
  logic [ADD_W-1:0]       alu_b;
  logic                   alu_sub;
  logic [ADD_W:0]         alu_res;
  logic                   alu_ge;

  // Per-sample decode
  logic [SAMPLE_BITS-1:0] s_in;
  logic [LEN_W-1:0]       spp_ext;
  logic [LEN_W-1:0]       len;
  logic [CNT_W-1:0]       pos_inc;
  logic                   is_last;
  logic [WIN_W-1:0]       win_lo;
  logic [WIN_W-1:0]       win_hi;
  logic                   in_win;
  logic                   included;
  logic [DEN_W:0]         trial;
  logic                   step_last;
  logic                   s_fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spp            <= wmv_pkg::SPP_RESET;
      exclude_enable <= 1'b0;
      centre_index   <= '0;
      half_width     <= '0;
    end else if (cfg_we) begin
      unique case (wmv_pkg::cfg_reg_t'(cfg_index))
        wmv_pkg::REG_SAMPLES_PER_PIXEL:  spp            <= cfg_data[wmv_pkg::SPP_W-1:0];
        wmv_pkg::REG_EXCLUDE_ENABLE:     exclude_enable <= cfg_data[0];
        wmv_pkg::REG_CENTRE_INDEX:       centre_index   <= cfg_data[wmv_pkg::CENTRE_W-1:0];
        wmv_pkg::REG_EXCLUDE_HALF_WIDTH: half_width     <= cfg_data[wmv_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode pixel length, last sample and exclusion window
  always_comb begin
    s_in    = SAMPLE_BITS'(s_tdata);
    spp_ext = LEN_W'(spp);
    if (spp == '0) begin
      len = LEN_W'(1);
    end else if (spp_ext > LEN_W'(MAX_SAMPLES)) begin
      len = LEN_W'(MAX_SAMPLES);
    end else begin
      len = spp_ext;
    end
    pos_inc  = CNT_W'(pos) + CNT_W'(1);
    is_last  = LEN_W'(pos_inc) >= len;
    win_lo   = WIN_W'(pos) + WIN_W'(half_width);
    win_hi   = WIN_W'(centre_index) + WIN_W'(half_width);
    in_win   = (win_lo >= WIN_W'(centre_index)) && (WIN_W'(pos) <= win_hi);
    included = !(exclude_enable && in_win);
  end

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // Steer the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    trial   = {rem, dvd[DVD_W-1]};
    unique case (state)
      ST_ACC_SUM: begin
        alu_a = ADD_W'(sum);
        alu_b = ADD_W'(s_reg);
      end
      ST_ACC_SQ: begin
        alu_a = ADD_W'(sumsq);
        alu_b = ADD_W'(sq_reg);
      end
      ST_MUL_A, ST_MUL_B, ST_MUL_C: begin
        alu_a = acc;
        alu_b = mplier[0] ? mcand : '0;
      end
      ST_SUB: begin
        alu_a   = t1;
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      ST_DIVV, ST_DIVM: begin
        alu_a   = ADD_W'(trial);
        alu_b   = ADD_W'(den);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
            + {{ADD_W{1'b0}}, alu_sub};
    alu_ge  = alu_res[ADD_W];
  end

  assign step_last = (cnt == '0);

  // Sequence accumulation, multiplies and divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      sum      <= '0;
      sumsq    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise the result at pixel close, drop it once taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            s_reg    <= s_in;
            last_reg <= is_last;
            pos      <= is_last ? '0 : pos_inc[POS_W-1:0];
            if (included) begin
              state <= ST_ACC_SUM;
            end else if (is_last) begin
              state <= ST_FIN;
            end
          end
        end
        ST_ACC_SUM: begin
          sum    <= alu_res[SUM_W-1:0];
          sq_reg <= s_reg * s_reg;
          state  <= ST_ACC_SQ;
        end
        ST_ACC_SQ: begin
          sumsq <= alu_res[SQ_W-1:0];
          count <= count + CNT_W'(1);
          state <= last_reg ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (count == '0) begin
            mean_r <= '0;
            var_r  <= '0;
            state  <= ST_DONE;
          end else if (count == CNT_W'(1)) begin
            var_r <= '0;
            dvd   <= DVD_W'(sum) << wmv_pkg::FRAC_BITS;
            den   <= DEN_W'(count);
            rem   <= '0;
            cnt   <= CTR_W'(DVD_W - 1);
            state <= ST_DIVM;
          end else begin
            acc    <= '0;
            mcand  <= ADD_W'(sumsq);
            mplier <= SUM_W'(count);
            cnt    <= CTR_W'(CNT_W - 1);
            state  <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          if (step_last) begin
            t1     <= alu_res[ADD_W-1:0];
            acc    <= '0;
            mcand  <= ADD_W'(sum);
            mplier <= sum;
            cnt    <= CTR_W'(SUM_W - 1);
            state  <= ST_MUL_B;
          end else begin
            acc    <= alu_res[ADD_W-1:0];
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - CTR_W'(1);
          end
        end
        ST_MUL_B: begin
          acc    <= alu_res[ADD_W-1:0];
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - CTR_W'(1);
          if (step_last) begin
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          t1     <= alu_res[ADD_W-1:0];
          acc    <= '0;
          mcand  <= ADD_W'(count);
          mplier <= SUM_W'(count - CNT_W'(1));
          cnt    <= CTR_W'(CNT_W - 1);
          state  <= ST_MUL_C;
        end
        ST_MUL_C: begin
          if (step_last) begin
            den   <= alu_res[DEN_W-1:0];
            dvd   <= DVD_W'(t1) << wmv_pkg::FRAC_BITS;
            rem   <= '0;
            cnt   <= CTR_W'(DVD_W - 1);
            state <= ST_DIVV;
          end else begin
            acc    <= alu_res[ADD_W-1:0];
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - CTR_W'(1);
          end
        end
        ST_DIVV: begin
          if (step_last) begin
            var_r <= wmv_pkg::VAR_W'({dvd[DVD_W-2:0], alu_ge});
            dvd   <= DVD_W'(sum) << wmv_pkg::FRAC_BITS;
            den   <= DEN_W'(count);
            rem   <= '0;
            cnt   <= CTR_W'(DVD_W - 1);
            state <= ST_DIVM;
          end else begin
            rem <= alu_ge ? alu_res[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd <= {dvd[DVD_W-2:0], alu_ge};
            cnt <= cnt - CTR_W'(1);
          end
        end
        ST_DIVM: begin
          rem <= alu_ge ? alu_res[DEN_W-1:0] : trial[DEN_W-1:0];
          dvd <= {dvd[DVD_W-2:0], alu_ge};
          cnt <= cnt - CTR_W'(1);
          if (step_last) begin
            mean_r <= wmv_pkg::MEAN_W'({dvd[DVD_W-2:0], alu_ge});
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free, then clear the accumulators
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {var_r, mean_r};
            m_tuser  <= wmv_pkg::OUT_USER_W'(count < CNT_W'(2));
            sum      <= '0;
            sumsq    <= '0;
            count    <= '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Flagged results carry zero variance
  a_flag_zero_var: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[wmv_pkg::OUT_DATA_W-1:wmv_pkg::MEAN_W] == '0))
    else $error("flagged result with non-zero variance");

  // A new result only appears after the close of a pixel
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside pixel close");

  // Divisions never run with a zero divisor
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIVV) || (state == ST_DIVM)) |-> (den != '0))
    else $error("division with zero divisor");

  // The included count never exceeds the longest pixel
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(MAX_SAMPLES)))
    else $error("included count beyond pixel length");

endmodule

`default_nettype wire
